[hdl/json_string_unescape_assert.svh]
// Assertion macros shared by the string unescaper RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

[hdl/jsu_pkg.sv]
// Types, codes and character helpers for the string unescaper.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int CHAR_W = 16;
    localparam int ACC_W  = 12;
    localparam int TUSER_W = 3;

    typedef enum logic [2:0] {
        PH_TEXT = 3'd0,
        PH_ESC  = 3'd1,
        PH_HEX1 = 3'd2,
        PH_HEX2 = 3'd3,
        PH_HEX3 = 3'd4,
        PH_HEX4 = 3'd5,
        PH_FAIL = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_ESCAPE  = 2'd1,
        ST_BAD_UNICODE = 2'd2
    } t_status;

    localparam logic [CHAR_W-1:0] C_BSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] C_QUOTE  = 16'h0022;
    localparam logic [CHAR_W-1:0] C_SLASH  = 16'h002F;
    localparam logic [CHAR_W-1:0] C_LOW_U  = 16'h0075;
    localparam logic [CHAR_W-1:0] C_LOW_B  = 16'h0062;
    localparam logic [CHAR_W-1:0] C_LOW_F  = 16'h0066;
    localparam logic [CHAR_W-1:0] C_LOW_N  = 16'h006E;
    localparam logic [CHAR_W-1:0] C_LOW_R  = 16'h0072;
    localparam logic [CHAR_W-1:0] C_LOW_T  = 16'h0074;
    localparam logic [CHAR_W-1:0] C_BS     = 16'h0008;
    localparam logic [CHAR_W-1:0] C_FF     = 16'h000C;
    localparam logic [CHAR_W-1:0] C_LF     = 16'h000A;
    localparam logic [CHAR_W-1:0] C_CR     = 16'h000D;
    localparam logic [CHAR_W-1:0] C_TAB    = 16'h0009;

    typedef struct packed {
        logic              valid;
        logic [3:0]        value;
    } t_hex;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] value;
    } t_esc;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_present;
        t_status           status;
        logic              out_last;
    } t_result;

    function automatic t_hex f_hex_digit(input logic [CHAR_W-1:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            h.value = c[3:0];
        end else if ((c >= 16'h0041 && c <= 16'h0046) || (c >= 16'h0061 && c <= 16'h0066)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic t_esc f_simple_esc(input logic [CHAR_W-1:0] c);
        t_esc e;
        e.valid = 1'b1;
        case (c)
            C_QUOTE:  e.value = C_QUOTE;
            C_BSLASH: e.value = C_BSLASH;
            C_SLASH:  e.value = C_SLASH;
            C_LOW_B:  e.value = C_BS;
            C_LOW_F:  e.value = C_FF;
            C_LOW_N:  e.value = C_LF;
            C_LOW_R:  e.value = C_CR;
            C_LOW_T:  e.value = C_TAB;
            default: begin
                e.valid = 1'b0;
                e.value = '0;
            end
        endcase
        return e;
    endfunction

endpackage

[hdl/jsu_in_reg.sv]
// Input register of the string unescaper: holds one accepted word.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_in_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [jsu_pkg::CHAR_W-1:0] i_char,
    input  logic                      i_last,
    input  logic                      i_advance,
    output logic                      o_ready,
    output logic                      o_valid,
    output logic [jsu_pkg::CHAR_W-1:0] o_char,
    output logic                      o_last
);
    import jsu_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

[hdl/jsu_decode.sv]
// Escape decoder: phase, hex accumulator and stored error, plus result logic.
// Depends on jsu_pkg and json_string_unescape_assert.svh.
`timescale 1ns / 1ps
`include "json_string_unescape_assert.svh"

module jsu_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [jsu_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_last,
    output logic                       o_emit,
    output jsu_pkg::t_result           o_res
);
    import jsu_pkg::*;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    t_status          r_err;
    t_status          n_err;
    t_hex             hx;
    t_esc             se;

    assign hx = f_hex_digit(i_char);
    assign se = f_simple_esc(i_char);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_err   = r_err;
        o_emit  = 1'b0;
        o_res.out_char     = '0;
        o_res.char_present = 1'b0;
        o_res.status       = ST_OK;
        o_res.out_last     = i_last;
        unique case (r_phase) inside
            PH_TEXT: begin
                if (i_char == C_BSLASH) begin
                    n_phase = PH_ESC;
                    if (i_last) begin
                        o_emit       = 1'b1;
                        o_res.status = ST_BAD_ESCAPE;
                    end
                end else begin
                    o_emit             = 1'b1;
                    o_res.out_char     = i_char;
                    o_res.char_present = 1'b1;
                end
            end
            PH_ESC: begin
                if (i_char == C_LOW_U) begin
                    n_phase = PH_HEX1;
                    n_acc   = '0;
                    if (i_last) begin
                        o_emit       = 1'b1;
                        o_res.status = ST_BAD_UNICODE;
                    end
                end else if (se.valid) begin
                    n_phase            = PH_TEXT;
                    o_emit             = 1'b1;
                    o_res.out_char     = se.value;
                    o_res.char_present = 1'b1;
                end else begin
                    n_phase      = PH_FAIL;
                    n_err        = ST_BAD_ESCAPE;
                    n_acc        = '0;
                    o_emit       = 1'b1;
                    o_res.status = ST_BAD_ESCAPE;
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3: begin
                if (!hx.valid) begin
                    n_phase      = PH_FAIL;
                    n_err        = ST_BAD_UNICODE;
                    n_acc        = '0;
                    o_emit       = 1'b1;
                    o_res.status = ST_BAD_UNICODE;
                end else begin
                    n_acc = {r_acc[ACC_W-5:0], hx.value};
                    if (r_phase == PH_HEX1) begin
                        n_phase = PH_HEX2;
                    end else if (r_phase == PH_HEX2) begin
                        n_phase = PH_HEX3;
                    end else begin
                        n_phase = PH_HEX4;
                    end
                    if (i_last) begin
                        o_emit       = 1'b1;
                        o_res.status = ST_BAD_UNICODE;
                    end
                end
            end
            PH_HEX4: begin
                if (!hx.valid) begin
                    n_phase      = PH_FAIL;
                    n_err        = ST_BAD_UNICODE;
                    n_acc        = '0;
                    o_emit       = 1'b1;
                    o_res.status = ST_BAD_UNICODE;
                end else begin
                    n_phase            = PH_TEXT;
                    n_acc              = '0;
                    o_emit             = 1'b1;
                    o_res.out_char     = {r_acc, hx.value};
                    o_res.char_present = 1'b1;
                end
            end
            PH_FAIL: begin
                if (i_last) begin
                    o_emit       = 1'b1;
                    o_res.status = r_err;
                end
            end
            default: begin
                n_phase            = PH_TEXT;
                n_acc              = '0;
                n_err              = ST_OK;
                o_emit             = 1'b1;
                o_res.out_char     = i_char;
                o_res.char_present = 1'b1;
            end
        endcase
        // end of string: back to reset state
        if (i_last) begin
            n_phase = PH_TEXT;
            n_acc   = '0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_acc   <= '0;
            r_err   <= ST_OK;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_err   <= n_err;
        end
    end

    `JSU_ASSERT_IMP(a_fail_has_err, i_clk, i_rst_n, r_phase == PH_FAIL, r_err != ST_OK)
    `JSU_ASSERT_IMP(a_err_only_in_fail, i_clk, i_rst_n, r_phase != PH_FAIL, r_err == ST_OK)
    `JSU_ASSERT_IMP(a_acc_clear_early, i_clk, i_rst_n,
        r_phase == PH_TEXT || r_phase == PH_ESC || r_phase == PH_HEX1, r_acc == '0)

endmodule

[hdl/jsu_out_reg.sv]
// Result register of the string unescaper, drives the master-side stream.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_out_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic                       i_emit,
    input  jsu_pkg::t_result           i_res,
    input  logic                       i_ready,
    output logic                       o_free,
    output logic                       o_valid,
    output jsu_pkg::t_result           o_res
);
    import jsu_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load ? i_emit : (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_emit) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[hdl/json_string_unescape.sv]
// JSON string unescaper, top level.
// Use: escaped string text enters on the s_axis side, one 16-bit character per
// word, tlast on the final character of each string. Decoded characters and
// error reports leave on the m_axis side, zero or one word per input word.
// Ordinary characters pass through; \" \\ \/ \b \f \n \r \t and \uXXXX decode.
// tuser bit 0 marks a decoded character; bits 2:1 give the status (0 ok,
// 1 bad or truncated escape, 2 bad or truncated \u). After an error nothing is
// sent until tlast, which repeats the error. Every tlast input word yields one
// output word with tlast set.
// Path: input register, combinational decoder, result register; a word moves on when the
// result register is free. Throughput: one word per cycle while i_m_axis_tready is high.
// Reset: synchronous active-low i_rst_n empties both registers and returns the
// decoder to plain-text phase.
// Stall: when i_m_axis_tready is low the result register holds, the input
// register fills, and then o_s_axis_tready drops.
// Depends on jsu_pkg, jsu_in_reg, jsu_decode, jsu_out_reg and the assert header.
`timescale 1ns / 1ps
`include "json_string_unescape_assert.svh"

module json_string_unescape (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [jsu_pkg::CHAR_W-1:0]  i_s_axis_tdata,  // [15:0] in_char
    input  logic                        i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [jsu_pkg::CHAR_W-1:0]  o_m_axis_tdata,  // [15:0] out_char
    output logic [jsu_pkg::TUSER_W-1:0] o_m_axis_tuser,  // [0] char_present, [2:1] status
    output logic                        o_m_axis_tlast
);
    import jsu_pkg::*;

    logic              in_valid;
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
    logic              out_free;
    logic              advance;
    logic              dec_emit;
    t_result           dec_res;
    t_result           out_res;

    assign advance = in_valid && out_free;

    jsu_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_char    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_advance (advance),
        .o_ready   (o_s_axis_tready),
        .o_valid   (in_valid),
        .o_char    (in_char),
        .o_last    (in_last)
    );

    jsu_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (advance),
        .i_char  (in_char),
        .i_last  (in_last),
        .o_emit  (dec_emit),
        .o_res   (dec_res)
    );

    jsu_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_emit  (dec_emit),
        .i_res   (dec_res),
        .i_ready (i_m_axis_tready),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = out_res.out_char;
    assign o_m_axis_tuser = {out_res.status, out_res.char_present};
    assign o_m_axis_tlast = out_res.out_last;

    `JSU_ASSERT_IMP(a_char_means_ok, i_clk, i_rst_n,
        o_m_axis_tvalid && out_res.char_present, out_res.status == ST_OK)
    `JSU_ASSERT_IMP(a_error_no_char, i_clk, i_rst_n,
        o_m_axis_tvalid && !out_res.char_present, out_res.out_char == '0)
    `JSU_ASSERT_NXT(a_last_emits, i_clk, i_rst_n, advance && in_last, o_m_axis_tvalid)

endmodule

[dv/json_string_unescape_tb.sv]
// Self-checking testbench for json_string_unescape: directed and random escaped strings,
// random stalls on both stream sides, and a long receiver hold-off.
// Depends on jsu_pkg and the json_string_unescape RTL.
`timescale 1ns / 1ps

module json_string_unescape_tb;
    import jsu_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [CHAR_W-1:0]    i_s_axis_tdata = '0;  // [15:0] in_char
    logic                 i_s_axis_tlast = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]    o_m_axis_tdata;       // [15:0] out_char
    logic [TUSER_W-1:0]   o_m_axis_tuser;       // [0] char_present, [2:1] status
    logic                 o_m_axis_tlast;

    json_string_unescape dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    t_phase            dec_phase = PH_TEXT;
    logic [ACC_W-1:0]  dec_acc = '0;
    t_status           dec_err = ST_OK;

    t_result           decoded_q[$];
    logic [CHAR_W-1:0] str_buf[$];

    int  mismatches = 0;
    int  chars_sent = 0;
    int  strings_sent = 0;
    int  words_checked = 0;
    int  fault_strings = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    bit  tx_no_gap = 1'b0;
    bit  rx_steady = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit hex_nibble(input logic [CHAR_W-1:0] c, output logic [3:0] v);
        v = '0;
        if (c >= 16'h0030 && c <= 16'h0039) v = 4'(c - 16'h0030);
        else if (c >= 16'h0041 && c <= 16'h0046) v = 4'(c - 16'h0041 + 16'd10);
        else if (c >= 16'h0061 && c <= 16'h0066) v = 4'(c - 16'h0061 + 16'd10);
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit esc_target(input logic [CHAR_W-1:0] c, output logic [CHAR_W-1:0] v);
        v = '0;
        case (c)
            C_QUOTE:  v = C_QUOTE;
            C_BSLASH: v = C_BSLASH;
            C_SLASH:  v = C_SLASH;
            C_LOW_B:  v = C_BS;
            C_LOW_F:  v = C_FF;
            C_LOW_N:  v = C_LF;
            C_LOW_R:  v = C_CR;
            C_LOW_T:  v = C_TAB;
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void enter_fault(input t_status st, input logic last, output t_result r);
        dec_phase = PH_FAIL;
        dec_err   = st;
        dec_acc   = '0;
        r = '{out_char: '0, char_present: 1'b0, status: st, out_last: last};
    endfunction

    function automatic bit decode_char(input logic [CHAR_W-1:0] c, input logic last,
                                       output t_result r);
        bit               has;
        logic [3:0]       nib;
        logic [CHAR_W-1:0] tgt;
        has = 1'b0;
        r = '{out_char: c, char_present: 1'b1, status: ST_OK, out_last: last};
        case (dec_phase)
            PH_TEXT: begin
                if (c == C_BSLASH) begin
                    dec_phase = PH_ESC;
                    if (last) begin
                        enter_fault(ST_BAD_ESCAPE, last, r);
                        has = 1'b1;
                    end
                end else begin
                    has = 1'b1;
                end
            end
            PH_ESC: begin
                has = 1'b1;
                if (c == C_LOW_U) begin
                    dec_phase = PH_HEX1;
                    dec_acc   = '0;
                    has = last;
                    if (last) enter_fault(ST_BAD_UNICODE, last, r);
                end else if (esc_target(c, tgt)) begin
                    dec_phase  = PH_TEXT;
                    r.out_char = tgt;
                end else begin
                    enter_fault(ST_BAD_ESCAPE, last, r);
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3: begin
                if (!hex_nibble(c, nib)) begin
                    enter_fault(ST_BAD_UNICODE, last, r);
                    has = 1'b1;
                end else begin
                    dec_acc   = {dec_acc[ACC_W-5:0], nib};
                    dec_phase = t_phase'(dec_phase + 3'd1);
                    if (last) begin
                        enter_fault(ST_BAD_UNICODE, last, r);
                        has = 1'b1;
                    end
                end
            end
            PH_HEX4: begin
                has = 1'b1;
                if (!hex_nibble(c, nib)) begin
                    enter_fault(ST_BAD_UNICODE, last, r);
                end else begin
                    r.out_char = {dec_acc, nib};
                    dec_phase  = PH_TEXT;
                    dec_acc    = '0;
                end
            end
            PH_FAIL: begin
                if (last) begin
                    r = '{out_char: '0, char_present: 1'b0, status: dec_err, out_last: 1'b1};
                    has = 1'b1;
                end
            end
            default: begin
                dec_phase = PH_TEXT;
                dec_acc   = '0;
                dec_err   = ST_OK;
                has = 1'b1;
            end
        endcase
        if (has && last) begin
            dec_phase = PH_TEXT;
            dec_acc   = '0;
            dec_err   = ST_OK;
        end
        return has;
    endfunction

    task automatic report_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch (%s): expected char %h present %b status %0d last %b, ",
                      "got char %h present %b status %0d last %b"},
                     what, want.out_char, want.char_present, want.status, want.out_last,
                     got.out_char, got.char_present, got.status, got.out_last);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        int      gap;
        t_result r;
        gap = (!tx_no_gap && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        chars_sent++;
        if (decode_char(c, last, r)) begin
            decoded_q.push_back(r);
            if (r.out_last && r.status != ST_OK) fault_strings++;
        end
    endtask

    task automatic send_string();
        for (int i = 0; i < str_buf.size(); i++)
            send_char(str_buf[i], i == str_buf.size() - 1);
        strings_sent++;
    endtask

    function automatic logic [CHAR_W-1:0] hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) return 16'(16'h0030 + k);
        if (k < 16) return 16'(16'h0041 + k - 10);
        return 16'(16'h0061 + k - 16);
    endfunction

    function automatic logic [CHAR_W-1:0] non_hex_char();
        logic [CHAR_W-1:0] c;
        logic [3:0]        v;
        case ($urandom_range(0, 11))
            0: return 16'h002F;
            1: return 16'h003A;
            2: return 16'h0040;
            3: return 16'h0047;
            4: return 16'h0060;
            5: return 16'h0067;
            default: begin
                do c = 16'($urandom_range(0, 16'hFFFF)); while (hex_nibble(c, v));
                return c;
            end
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] esc_letter();
        case ($urandom_range(0, 7))
            0: return C_QUOTE;
            1: return C_BSLASH;
            2: return C_SLASH;
            3: return C_LOW_B;
            4: return C_LOW_F;
            5: return C_LOW_N;
            6: return C_LOW_R;
            default: return C_LOW_T;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] bad_letter();
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] v;
        do begin
            c = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(16'h20, 16'h7E))
                                            : 16'($urandom_range(0, 16'hFFFF));
        end while (c == C_LOW_U || esc_target(c, v));
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] c;
        do begin
            case ($urandom_range(0, 9))
                0:       c = 16'h0000;
                1:       c = 16'hFFFF;
                2, 3, 4: c = 16'($urandom_range(16'h20, 16'h7E));
                default: c = 16'($urandom_range(0, 16'hFFFF));
            endcase
        end while (c == C_BSLASH);
        return c;
    endfunction

    // Build one string: mostly well-formed content, sometimes ending in a fault.
    task automatic make_string();
        int n;
        int r;
        int k;
        str_buf.delete();
        n = $urandom_range(1, 10);
        repeat (n) begin
            case ($urandom_range(0, 9))
                4, 5: begin
                    str_buf.push_back(C_BSLASH);
                    str_buf.push_back(esc_letter());
                end
                6, 7: begin
                    str_buf.push_back(C_BSLASH);
                    str_buf.push_back(C_LOW_U);
                    repeat (4) str_buf.push_back(hex_char());
                end
                default: str_buf.push_back(plain_char());
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 20) begin
            str_buf.push_back(C_BSLASH);
            if (r < 7) begin
                str_buf.push_back(bad_letter());
            end else begin
                str_buf.push_back(C_LOW_U);
                k = $urandom_range(0, 3);
                repeat (k) str_buf.push_back(hex_char());
                if (r < 14) str_buf.push_back(non_hex_char());
            end
            if (r < 14) begin
                k = $urandom_range(0, 4);
                repeat (k) begin
                    str_buf.push_back(($urandom_range(0, 3) == 0) ? C_BSLASH
                                                                  : plain_char());
                end
            end
        end
    endtask

    task automatic test_directed();
        str_buf = '{16'h0000, 16'hFFFF, C_BSLASH, C_LOW_N, C_BSLASH, C_LOW_U,
                    16'h0061, 16'h0046, 16'h0030, 16'h0039};
        send_string();
        str_buf = '{C_BSLASH, 16'h0071, 16'h007A, 16'h0079};
        send_string();
        str_buf = '{C_BSLASH};
        send_string();
        str_buf = '{C_BSLASH, C_LOW_U};
        send_string();
        str_buf = '{C_BSLASH, C_LOW_U, 16'h0031};
        send_string();
        str_buf = '{C_BSLASH, C_LOW_U, 16'h0031, 16'h0047, 16'h0061};
        send_string();
    endtask

    task automatic test_random_strings(input int n_chars);
        int stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            make_string();
            send_string();
        end
    endtask

    task automatic test_back_to_back(input int n_chars);
        tx_no_gap = 1'b1;
        rx_steady = 1'b1;
        test_random_strings(n_chars);
        tx_no_gap = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_receiver_hold(input int n_chars);
        hold_reqs <= hold_reqs + 1;
        tx_no_gap = 1'b1;
        test_random_strings(n_chars);
        tx_no_gap = 1'b0;
    endtask

    // Raw noise: escapes, u, hex digits, escape letters and arbitrary characters at random.
    task automatic test_noise(input int n_chars);
        int stop_at;
        int n;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            str_buf.delete();
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5: str_buf.push_back(C_BSLASH);
                    6, 7, 8:          str_buf.push_back(C_LOW_U);
                    9, 10, 11, 12:    str_buf.push_back(hex_char());
                    13, 14:           str_buf.push_back(esc_letter());
                    default:          str_buf.push_back(16'($urandom_range(0, 16'hFFFF)));
                endcase
            end
            send_string();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen       <= hold_reqs;
            stall_left      <= HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
            stall_left      <= pick_gap() - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_words
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.out_char     = o_m_axis_tdata;
            got.char_present = o_m_axis_tuser[0];
            got.status       = t_status'(o_m_axis_tuser[2:1]);
            got.out_last     = o_m_axis_tlast;
            words_checked++;
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected word", '0, got);
            end else begin
                want = decoded_q.pop_front();
                if (got.out_char !== want.out_char || got.char_present !== want.char_present ||
                    got.status !== want.status || got.out_last !== want.out_last)
                    report_mismatch("wrong word", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles, %0d words outstanding",
                         idle_cycles, decoded_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_strings(900);
        test_back_to_back(150);
        test_receiver_hold(120);
        test_noise(150);
        test_random_strings(200);
        i_s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (decoded_q.size() != 0)
            report_mismatch("missing word", decoded_q.pop_front(), '0);
        $display("covered %0d strings, %0d chars in, %0d words out", strings_sent, chars_sent,
                 words_checked);
        $display("%0d strings ended in a fault report, %0d mismatches", fault_strings,
                 mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_in_reg.sv
hdl/jsu_decode.sv
hdl/jsu_out_reg.sv
hdl/json_string_unescape.sv
dv/json_string_unescape_tb.sv
